// File: hdl/fde_pkg.sv
// Package for the flanger delay effect: state and register codes, command and
// status structs, reset values and the raised-cosine table functions.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package fde_pkg;

  // Default sizing of the block.
  localparam int MAX_DELAY_DEF      = 4096;
  localparam int CHANNELS_DEF       = 2;
  localparam int COS_TABLE_BITS_DEF = 10;

  // Register widths and reset values.
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int DLEN_W       = 13;
  localparam int WET_W        = 16;
  localparam int SAMPLE_W     = 16;
  localparam int HCOS_W       = 17;
  localparam int PHASE_W      = 32;

  localparam logic [DLEN_W-1:0]  DELAY_LENGTH_RST = 13'd2400;
  localparam logic [PHASE_W-1:0] PHASE_STEP_RST   = 32'd894785;
  localparam logic [WET_W-1:0]   WET_GAIN_RST     = 16'd32768;
  localparam logic [WET_W-1:0]   WET_ONE          = 16'd32768;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH = 2'd0,
    REG_PHASE_STEP   = 2'd1,
    REG_WET_GAIN     = 2'd2
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DELAY,
    ST_READ,
    ST_PROD,
    ST_OUT
  } fde_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // write zero at the clearing counter and advance it
    logic load;      // an input beat is taken: capture sample and lookups
    logic commit;    // write the sample, compute the delay, advance state
    logic read;      // compute the tap address and read the delay line
    logic prod;      // form the wet product
    logic out_load;  // load the mixed sample into the output register
  } fde_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // clearing counter is on the last entry
    logic out_free;    // output register can take a new beat this cycle
  } fde_sts_t;

  // cos(pi*u/2) for u in Q0.16, result in Q0.16; elaboration-time only.
  function automatic longint unsigned quarter_cos(input longint unsigned u);
    longint unsigned u2;
    longint unsigned p;
    u2 = (u * u) >> 16;
    p  = 64'd60;
    p  = 64'd1367 - ((p * u2) >> 16);
    p  = 64'd16625 - ((p * u2) >> 16);
    p  = 64'd80852 - ((p * u2) >> 16);
    p  = (p * u2) >> 16;
    if (p >= 64'd65536) begin
      return 64'd0;
    end
    return 64'd65536 - p;
  endfunction

  // (1+cos)/2 in Q0.16 for entry k of a table of 2^bits entries.
  function automatic logic [HCOS_W-1:0] half_raised_cos(input int k, input int bits);
    int              qbits;
    int              quad;
    longint unsigned r;
    longint unsigned u;
    longint unsigned c;
    logic            neg;
    qbits = bits - 2;
    quad  = (k >> qbits) & 3;
    r     = longint'(k & ((1 << qbits) - 1));
    u     = r << (18 - bits);
    unique case (quad)
      0: begin
        c   = quarter_cos(u);
        neg = 1'b0;
      end
      1: begin
        c   = quarter_cos(64'd65536 - u);
        neg = 1'b1;
      end
      2: begin
        c   = quarter_cos(u);
        neg = 1'b1;
      end
      default: begin
        c   = quarter_cos(64'd65536 - u);
        neg = 1'b0;
      end
    endcase
    if (neg) begin
      return HCOS_W'((64'd65536 - c) >> 1);
    end
    return HCOS_W'((64'd65536 + c) >> 1);
  endfunction

endpackage

// File: hdl/fde_ctrl.sv
// Controller for the flanger delay effect: sequences the clearing pass and
// the steps of one sample through the datapath. Depends on fde_pkg.
`timescale 1ns / 1ps

module fde_ctrl
  import fde_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fde_sts_t sts_i,
  output fde_cmd_t cmd_o
);

  fde_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DELAY;
        end
      end
      ST_DELAY: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        // Hold the result here until the output register has room.
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/fde_datapath.sv
// Datapath for the flanger delay effect: configuration registers, oscillator,
// cosine ROM, delay line memory, write positions, mixer and output register.
// Depends on fde_pkg.
`timescale 1ns / 1ps

module fde_datapath
  import fde_pkg::*;
#(
  parameter int MaxDelay     = MAX_DELAY_DEF,
  parameter int Channels     = CHANNELS_DEF,
  parameter int CosTableBits = COS_TABLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       channel_i,
  input  logic                       out_stall_i,
  input  fde_cmd_t                   cmd_i,
  output fde_sts_t                   sts_o,
  output logic                       out_valid_o,
  output logic signed [SAMPLE_W-1:0] sample_out_o
);

  localparam int Depth    = Channels * MaxDelay;
  localparam int AW       = $clog2(Depth);
  localparam int PW       = $clog2(MaxDelay);
  localparam int LW       = $clog2(MaxDelay + 1);
  localparam int CW       = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int CosDepth = 2 ** CosTableBits;
  localparam int MW       = LW + HCOS_W;
  localparam int PRW      = 2 * (SAMPLE_W + 1);

  // Cosine ROM contents, built at elaboration.
  typedef logic [HCOS_W-1:0] cos_tab_t [CosDepth];

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    for (int k = 0; k < CosDepth; k++) begin
      tab[k] = half_raised_cos(k, CosTableBits);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  // Configuration registers.
  logic [DLEN_W-1:0]  delay_length_q;
  logic [PHASE_W-1:0] phase_step_q;
  logic [WET_W-1:0]   wet_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_length_q <= DELAY_LENGTH_RST;
      phase_step_q   <= PHASE_STEP_RST;
      wet_gain_q     <= WET_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DELAY_LENGTH: delay_length_q <= cfg_wdata_i[DLEN_W-1:0];
        REG_PHASE_STEP:   phase_step_q   <= cfg_wdata_i[PHASE_W-1:0];
        REG_WET_GAIN:     wet_gain_q     <= cfg_wdata_i[WET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective length and wet factor with their limits applied.
  logic [LW-1:0]    len_c;
  logic [WET_W-1:0] wet_c;
  logic             bypass_c;
  logic [CW-1:0]    ch_c;

  always_comb begin
    if (delay_length_q == '0) begin
      len_c = LW'(1);
    end else if (32'(delay_length_q) > MaxDelay) begin
      len_c = LW'(MaxDelay);
    end else begin
      len_c = LW'(delay_length_q);
    end
    wet_c    = (wet_gain_q > WET_ONE) ? WET_ONE : wet_gain_q;
    bypass_c = (32'(channel_i) >= Channels);
    ch_c     = bypass_c ? '0 : CW'(channel_i);
  end

  // Clearing counter, write positions and oscillator phase.
  logic [AW-1:0]      clr_q;
  logic [PW-1:0]      wpos_q [Channels];
  logic [PHASE_W-1:0] phase_q;

  // Per-sample working registers.
  logic signed [SAMPLE_W-1:0] x_q;
  logic [CW-1:0]              ch_q;
  logic                       bypass_q;
  logic [HCOS_W-1:0]          h_q;
  logic [LW-1:0]              len_q;
  logic [WET_W-1:0]           wet_q;
  logic [PW-1:0]              pos_q;
  logic [LW-1:0]              d_q;
  logic signed [SAMPLE_W-1:0] tap_q;
  logic signed [PRW-1:0]      prod_q;

  // Write position with a stale value folded to zero, and its successor.
  logic [PW-1:0] pos_fix;
  logic [LW-1:0] pos_inc;
  logic [PW-1:0] pos_next;
  logic [MW-1:0] dmul;
  logic [AW-1:0] wr_addr;

  always_comb begin
    pos_fix  = (LW'(pos_q) >= len_q) ? '0 : pos_q;
    pos_inc  = LW'(pos_fix) + LW'(1);
    pos_next = (pos_inc >= len_q) ? '0 : PW'(pos_inc);
    dmul     = MW'(len_q) * MW'(h_q);
    wr_addr  = AW'(ch_q) * AW'(MaxDelay) + AW'(pos_fix);
  end

  // Tap address: (pos + len - d) mod len, with a full-length delay as zero.
  logic [LW-1:0] d_eff;
  logic [LW:0]   rd_sum;
  logic [PW-1:0] rd_pos;
  logic [AW-1:0] rd_addr;

  always_comb begin
    d_eff   = (d_q >= len_q) ? '0 : d_q;
    rd_sum  = (LW + 1)'(pos_q) + (LW + 1)'(len_q) - (LW + 1)'(d_eff);
    if (rd_sum >= (LW + 1)'(len_q)) begin
      rd_pos = PW'(rd_sum - (LW + 1)'(len_q));
    end else begin
      rd_pos = PW'(rd_sum);
    end
    rd_addr = AW'(ch_q) * AW'(MaxDelay) + AW'(rd_pos);
  end

  // Control state: clearing counter, write positions, phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      phase_q <= '0;
      for (int c = 0; c < Channels; c++) begin
        wpos_q[c] <= '0;
      end
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.commit && !bypass_q) begin
        wpos_q[ch_q] <= pos_next;
        phase_q      <= phase_q + phase_step_q;
      end
    end
  end

  assign sts_o.clear_last = (clr_q == AW'(Depth - 1));

  // Working registers of one sample.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q      <= sample_in_i;
      ch_q     <= ch_c;
      bypass_q <= bypass_c;
      h_q      <= COS_TAB[phase_q[PHASE_W-1 -: CosTableBits]];
      len_q    <= len_c;
      wet_q    <= wet_c;
      pos_q    <= wpos_q[ch_c];
    end
    if (cmd_i.commit) begin
      pos_q <= pos_fix;
      d_q   <= LW'(dmul >> 16);
    end
  end

  // Delay line memory: one write port, one registered read port.
  logic [SAMPLE_W-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[clr_q] <= '0;
    end else if (cmd_i.commit && !bypass_q) begin
      mem_q[wr_addr] <= x_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      tap_q <= mem_q[rd_addr];
    end
  end

  // Wet product (tap - x) * wet.
  logic signed [PRW-1:0] diff_s;
  logic signed [PRW-1:0] wet_s;

  always_comb begin
    diff_s = PRW'(tap_q) - PRW'(x_q);
    wet_s  = signed'(PRW'(wet_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      prod_q <= diff_s * wet_s;
    end
  end

  // Rounding half up, add the dry sample, saturate.
  logic signed [PRW:0]   prod_rnd;
  logic signed [PRW:0]   mix_sum;
  logic signed [SAMPLE_W-1:0] mix_sat;

  always_comb begin
    prod_rnd = (PRW + 1)'(prod_q) + (PRW + 1)'(32768);
    mix_sum  = (prod_rnd >>> 16) + (PRW + 1)'(x_q);
    if (mix_sum > (PRW + 1)'(32767)) begin
      mix_sat = 16'sh7FFF;
    end else if (mix_sum < -(PRW + 1)'(32768)) begin
      mix_sat = 16'sh8000;
    end else begin
      mix_sat = SAMPLE_W'(mix_sum);
    end
  end

  // Output register.
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_data_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= bypass_q ? x_q : mix_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

endmodule

// File: hdl/flanger_delay_effect_top.sv
// Flanger delay effect, top level: a sample beat goes in, a flanged sample beat
// comes out. Each beat runs the controller's step sequence (load, delay multiply
// and write, memory read, wet multiply, output); the output step waits until the
// output register has room, and a new beat is taken only once the last is loaded.
// After reset the delay memory is swept to zero, all CHANNELS*MAX_DELAY entries
// (8192 by default), with in_stall_o high. Depends on fde_pkg, fde_ctrl, fde_datapath.
`timescale 1ns / 1ps

module flanger_delay_effect_top
  import fde_pkg::*;
#(
  parameter int MaxDelay     = MAX_DELAY_DEF,
  parameter int Channels     = CHANNELS_DEF,
  parameter int CosTableBits = COS_TABLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       channel_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o
);

  fde_cmd_t cmd;
  fde_sts_t sts;

  // Step sequencer.
  fde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Delay line, oscillator and mixer.
  fde_datapath #(
    .MaxDelay     (MaxDelay),
    .Channels     (Channels),
    .CosTableBits (CosTableBits)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_in_i  (sample_in_i),
    .channel_i    (channel_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o)
  );

endmodule
